@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define FLG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("flanger assertion failed");

// Assertion that is also evaluated while reset is high.
`define FLG_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("flanger assertion failed");

`endif

@@ rtl/flg_pkg.sv @@
// ----------------------------------------------------------------------------
// flg_pkg
// Constants, register codes and elaboration-time tables of the flanger.
// ----------------------------------------------------------------------------
package flg_pkg;

  typedef logic [63:0] u64_t;

  localparam int DELAY_DEPTH      = 1024;
  localparam int DL_AW            = $clog2(DELAY_DEPTH);
  localparam int POS_W            = DL_AW + 8;
  localparam int SAMPLE_RATE      = 48000;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
  localparam int SAT_DRIVE_Q8     = 512;
  localparam int TANH_STEPS       = 256;
  localparam int TANH_AW          = $clog2(TANH_STEPS);
  localparam int SAT_UW           = 17 + $clog2(SAT_DRIVE_Q8 + 1);

  localparam int BLEND_A = 39322;
  localparam int BLEND_B = 26214;

  // Tap delay limits in Q.8 samples.
  localparam int DLY_HI_RAW = SAMPLE_RATE * 256 / 100;
  localparam int DLY_CAP    = (DELAY_DEPTH - 1) * 256;
  localparam int DLY_HI     = (DLY_HI_RAW > DLY_CAP) ? DLY_CAP : DLY_HI_RAW;
  localparam int DLY_LO_RAW = SAMPLE_RATE * 256 / 10000;
  localparam int DLY_LO     = (DLY_LO_RAW > DLY_HI) ? DLY_HI : DLY_LO_RAW;

  localparam u64_t ONE_Q30     = 64'd1073741824;
  localparam u64_t TWO_PI_Q30  = 64'd6746518852;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 19;
  typedef enum logic [CFG_AW-1:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_DEPTH        = 3'd1,
    REG_BASE_DELAY   = 3'd2,
    REG_FEEDBACK     = 3'd3,
    REG_WET_MIX      = 3'd4,
    REG_TAP_OFFSET   = 3'd5,
    REG_COMP_THRESH  = 3'd6,
    REG_COMP_RATIO   = 3'd7
  } cfg_reg_t;

  localparam logic [18:0] RST_PHASE_STEP  = 19'd44739;
  localparam logic [16:0] RST_DEPTH       = 17'd24576;
  localparam logic [16:0] RST_BASE_DELAY  = 17'd36864;
  localparam logic [15:0] RST_FEEDBACK    = 16'd32768;
  localparam logic [16:0] RST_WET_MIX     = 17'd32768;
  localparam logic [15:0] RST_TAP_OFFSET  = 16'd16384;
  localparam logic [14:0] RST_COMP_THRESH = 15'd16384;
  localparam logic [16:0] RST_COMP_RATIO  = 17'd32768;

  // Sequencer steps of one sample.
  typedef enum logic [4:0] {
    ST_IDLE, ST_MOD1, ST_HPF, ST_DLY1, ST_DLY2, ST_RD1B, ST_LPF, ST_TAP1A,
    ST_TAP1B, ST_TAP2A, ST_TAP2B, ST_DRY, ST_BLEND, ST_FBOP, ST_WETOP,
    ST_LLPF, ST_MIX, ST_SAT, ST_SATW, ST_CMP, ST_CMPW, ST_LOOP, ST_LOOPW,
    ST_FBWAIT, ST_WRITE
  } state_t;

  typedef logic [SINE_TABLE_DEPTH-1:0][15:0] sine_tab_t;
  typedef logic [TANH_STEPS:0][15:0]         tanh_tab_t;

  function automatic u64_t udiv64(input u64_t num, input u64_t dvs);
    u64_t q;
    u64_t r;
    int   i;
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= dvs) begin
        r    = r - dvs;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-y) in Q30 for y in Q30.
  function automatic u64_t exp_neg_q30(input u64_t y);
    u64_t z;
    u64_t z2;
    u64_t z3;
    u64_t e;
    int   i;
    z  = y >> 10;
    z2 = (z * z) >> 30;
    z3 = (z2 * z) >> 30;
    e  = ONE_Q30 - z + (z2 >> 1) - udiv64(z3, 64'd6);
    for (i = 0; i < 10; i++) e = (e * e + (ONE_Q30 >> 1)) >> 30;
    return e;
  endfunction

  function automatic logic [15:0] alpha_q16(input u64_t fc);
    u64_t e;
    u64_t a;
    e = exp_neg_q30(udiv64(fc * TWO_PI_Q30, 64'(SAMPLE_RATE)));
    a = ((ONE_Q30 - e) + 64'd8192) >> 14;
    return (a > 64'd65535) ? 16'hFFFF : a[15:0];
  endfunction

  // sin(x) in Q30 for x in [0, pi/2].
  function automatic longint sin_q30(input u64_t x);
    u64_t   x2;
    u64_t   term;
    u64_t   den;
    longint sum;
    int     n;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 5; n++) begin
      case (n)
        1:       den = 64'd6;
        2:       den = 64'd20;
        3:       den = 64'd42;
        4:       den = 64'd72;
        default: den = 64'd110;
      endcase
      term = udiv64((term * x2) >> 30, den);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return sum;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    u64_t      q;
    u64_t      r;
    longint    s;
    int        k;
    for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
      q = (64'(4 * k)) / SINE_TABLE_DEPTH;
      r = 64'(4 * k) - q * SINE_TABLE_DEPTH;
      if (q[0]) r = SINE_TABLE_DEPTH - r;
      s = sin_q30(HALF_PI_Q30 * r / SINE_TABLE_DEPTH);
      if (s < 0) s = 0;
      s = (s + 16384) >>> 15;
      if (s > 32767) s = 32767;
      t[k] = (q >= 2) ? 16'(-s) : 16'(s);
    end
    return t;
  endfunction

  function automatic tanh_tab_t build_tanh();
    tanh_tab_t t;
    u64_t      e;
    u64_t      v;
    int        k;
    for (k = 0; k <= TANH_STEPS; k++) begin
      e    = exp_neg_q30(64'(k) << 25);
      v    = udiv64((ONE_Q30 - e) << 15, ONE_Q30 + e);
      t[k] = v[15:0];
    end
    return t;
  endfunction

  localparam logic [15:0] ALPHA_HP = alpha_q16(64'd120);
  localparam logic [15:0] ALPHA_LP = alpha_q16(64'd7000);
  localparam logic [15:0] ALPHA_FB = alpha_q16(64'd8000);
  localparam sine_tab_t   SINE_TAB = build_sine();
  localparam tanh_tab_t   TANH_TAB = build_tanh();

endpackage

@@ rtl/flg_delay_mem.sv @@
// ----------------------------------------------------------------------------
// flg_delay_mem
// Circular delay memory with a running write pointer and a fill marker;
// entries not yet written since reset read as zero.
// ----------------------------------------------------------------------------
module flg_delay_mem (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic signed [15:0]         wr_data,
  input  logic [flg_pkg::DL_AW-1:0]  rd_addr,
  output logic signed [15:0]         rd_data,
  output logic [flg_pkg::DL_AW-1:0]  wr_ptr
);
  import flg_pkg::*;

  logic signed [15:0] mem [DELAY_DEPTH];
  logic signed [15:0] rd_raw;
  logic               full;
  logic               rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  // The pointer runs from zero after reset, so an entry has been written once
  // the memory has wrapped or the entry lies below the pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      full   <= 1'b0;
      rd_ok  <= 1'b0;
    end else begin
      rd_ok <= full || (rd_addr < wr_ptr);
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
        if (wr_ptr == DL_AW'(DELAY_DEPTH - 1)) begin
          full <= 1'b1;
        end
      end
    end
  end

  assign rd_data = rd_ok ? rd_raw : 16'sd0;

endmodule

@@ rtl/flanger_effect_top.sv @@
// ----------------------------------------------------------------------------
// flanger_effect_top
// Mono two-tap flanger with filtered input, modulated fractional delays and
// a saturating, compressed feedback loop.
// ----------------------------------------------------------------------------
// Each input transaction carries one Q1.15 sample and produces exactly one
// output transaction. After the sample is accepted in the idle state, 24
// steps of a sequencer follow before the block is ready for the next one;
// they run every product but the saturator's drive scaling through a single
// shared 26 x 18 signed multiplier with registered operands and a registered
// product, and read the four interpolation points from the 1024-entry delay
// memory one at a time through its single read port. The result sits in an
// output register, so a new sample is accepted while the previous result
// still waits; only the final step, which writes the delay memory and loads
// the output register, waits if that register is still occupied. The delay
// memory needs no clearing pass after reset: a fill marker makes unwritten
// entries read as zero. Configuration writes take effect at once and should
// only be made while no sample is in flight.
module flanger_effect_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_sample,
  input  logic                        cfg_we,
  input  logic [flg_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [flg_pkg::CFG_DW-1:0]  cfg_data
);
  import flg_pkg::*;

  localparam logic signed [19:0] D_LO = 20'(DLY_LO);
  localparam logic signed [19:0] D_HI = 20'(DLY_HI);

  // Configuration registers.
  logic [18:0] phase_step;
  logic [16:0] depth_samples;
  logic [16:0] base_delay;
  logic [15:0] feedback_gain;
  logic [16:0] wet_mix;
  logic [15:0] tap_phase_offset;
  logic [14:0] comp_threshold;
  logic [16:0] comp_ratio;

  // Sequencer and filter state.
  state_t state, state_next;
  logic [31:0]        lfo_phase;
  logic signed [23:0] hp_track;
  logic signed [23:0] lp_track;
  logic signed [23:0] loop_track;

  // Working registers of one sample.
  logic signed [15:0]   x_r;
  logic signed [24:0]   hp_r;
  logic [POS_W-1:0]     d1;
  logic [POS_W-1:0]     d2;
  logic signed [43:0]   acc;
  logic signed [43:0]   acc_dry;
  logic signed [15:0]   t1;
  logic signed [15:0]   t2;
  logic signed [15:0]   dec;
  logic signed [15:0]   y_r;
  logic signed [15:0]   lp_r;
  logic                 lp_neg;
  logic [15:0]          tb_r;
  logic [16:0]          t_r;

  // Shared multiplier.
  logic signed [25:0] opa;
  logic signed [17:0] opb;
  logic signed [43:0] prod;
  logic signed [43:0] prod_sh15;
  logic signed [43:0] prod_sh16;

  // Delay memory interface.
  logic                 mem_wr_en;
  logic signed [15:0]   mem_wr_data;
  logic [DL_AW-1:0]     mem_rd_addr;
  logic signed [15:0]   mem_rd_data;
  logic [DL_AW-1:0]     wr_ptr;

  // Combinational helpers.
  logic               accept;
  logic               out_free;
  logic [31:0]        phase2;
  logic signed [15:0] sine1;
  logic signed [15:0] sine2;
  logic signed [19:0] d_full;
  logic [POS_W-1:0]   d_clamped;
  logic [POS_W-1:0]   pos1;
  logic [POS_W-1:0]   pos2;
  logic [8:0]         frac1;
  logic [8:0]         frac2;
  logic [8:0]         inv1;
  logic [8:0]         inv2;
  logic signed [24:0] hp_diff;
  logic signed [24:0] hp_sat;
  logic signed [23:0] x256;
  logic signed [43:0] sum_acc;
  logic signed [43:0] sum_dry;
  logic signed [43:0] y_sh;
  logic signed [15:0] y_sat;
  logic [16:0]        mix;
  logic [16:0]        mix_inv;
  logic [16:0]        mag;
  logic [SAT_UW-1:0]  sat_u;
  logic [SAT_UW-18:0] sat_i;
  logic [15:0]        sat_frac;
  logic [15:0]        tanh_lo;
  logic [15:0]        tanh_hi;
  logic               sat_top;
  logic [16:0]        t_new;
  logic signed [17:0] t_over;
  logic [16:0]        comp_sum;
  logic [15:0]        t_comp;
  logic signed [16:0] loop_val;
  logic signed [17:0] w_sum;
  logic signed [15:0] w_sat;

  flg_delay_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mem_wr_en),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_ptr  (wr_ptr)
  );

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  assign prod_sh15 = prod >>> 15;
  assign prod_sh16 = prod >>> 16;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // The two LFO taps read the sine table at the current and the offset phase.
  assign phase2 = lfo_phase + {tap_phase_offset, 16'h0000};
  assign sine1  = SINE_TAB[lfo_phase[31 -: SINE_AW]];
  assign sine2  = SINE_TAB[phase2[31 -: SINE_AW]];

  // Tap delay: centre plus scaled sine, held to the legal window.
  always_comb begin
    d_full = $signed({3'b000, base_delay}) + prod_sh15[19:0];
    if (d_full < D_LO) begin
      d_clamped = POS_W'(DLY_LO);
    end else if (d_full > D_HI) begin
      d_clamped = POS_W'(DLY_HI);
    end else begin
      d_clamped = d_full[POS_W-1:0];
    end
  end

  // Read positions wrap around the circular buffer in Q.8 samples.
  assign pos1  = {wr_ptr, 8'h00} - d1;
  assign pos2  = {wr_ptr, 8'h00} - d2;
  assign frac1 = {1'b0, pos1[7:0]};
  assign frac2 = {1'b0, pos2[7:0]};
  assign inv1  = 9'd256 - frac1;
  assign inv2  = 9'd256 - frac2;

  // High-pass output with its difference held to the Q1.23 range.
  assign x256    = {x_r, 8'h00};
  assign hp_diff = {x256[23], x256} - {hp_track[23], hp_track};
  always_comb begin
    if (hp_diff > 25'sd8388607) begin
      hp_sat = 25'sd8388607;
    end else if (hp_diff < -25'sd8388608) begin
      hp_sat = -25'sd8388608;
    end else begin
      hp_sat = hp_diff;
    end
  end

  assign sum_acc = acc + prod;
  assign sum_dry = acc_dry + prod;
  assign y_sh    = sum_dry >>> 16;
  always_comb begin
    if (y_sh > 44'sd32767) begin
      y_sat = 16'sh7FFF;
    end else if (y_sh < -44'sd32768) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = y_sh[15:0];
    end
  end

  assign mix     = (wet_mix > 17'd65536) ? 17'd65536 : wet_mix;
  assign mix_inv = 17'd65536 - mix;

  // Saturator: tanh table at |lp| times the drive, linearly interpolated.
  assign mag      = lp_r[15] ? (17'd0 - {1'b1, lp_r}) : {1'b0, lp_r};
  assign sat_u    = SAT_UW'(mag) * SAT_UW'(SAT_DRIVE_Q8);
  assign sat_i    = sat_u[SAT_UW-1:17];
  assign sat_frac = sat_u[16:1];
  assign sat_top  = (sat_i >= (SAT_UW-17)'(TANH_STEPS));
  assign tanh_lo  = sat_top ? TANH_TAB[TANH_STEPS]
                            : TANH_TAB[{1'b0, sat_i[TANH_AW-1:0]}];
  assign tanh_hi  = sat_top ? TANH_TAB[TANH_STEPS]
                            : TANH_TAB[{1'b0, sat_i[TANH_AW-1:0]} + 1'b1];

  // Compression above the threshold, then the sign returns.
  assign t_new    = {1'b0, tb_r} + {1'b0, prod[31:16]};
  assign t_over   = $signed({1'b0, t_new}) - $signed({3'b000, comp_threshold});
  assign comp_sum = {2'b00, comp_threshold} + prod[32:16];
  always_comb begin
    if (t_r > {2'b00, comp_threshold}) begin
      t_comp = (comp_sum > 17'd32767) ? 16'd32767 : comp_sum[15:0];
    end else begin
      t_comp = t_r[15:0];
    end
  end
  assign loop_val = lp_neg ? -$signed({1'b0, t_comp}) : $signed({1'b0, t_comp});

  // Buffer write: filtered input plus scaled loop, saturated.
  assign w_sum = {{2{lp_track[23]}}, lp_track[23:8]} + prod_sh16[17:0];
  always_comb begin
    if (w_sum > 18'sd32767) begin
      w_sat = 16'sh7FFF;
    end else if (w_sum < -18'sd32768) begin
      w_sat = 16'sh8000;
    end else begin
      w_sat = w_sum[15:0];
    end
  end
  assign mem_wr_data = w_sat;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MOD1;
      ST_MOD1:   state_next = ST_HPF;
      ST_HPF:    state_next = ST_DLY1;
      ST_DLY1:   state_next = ST_DLY2;
      ST_DLY2:   state_next = ST_RD1B;
      ST_RD1B:   state_next = ST_LPF;
      ST_LPF:    state_next = ST_TAP1A;
      ST_TAP1A:  state_next = ST_TAP1B;
      ST_TAP1B:  state_next = ST_TAP2A;
      ST_TAP2A:  state_next = ST_TAP2B;
      ST_TAP2B:  state_next = ST_DRY;
      ST_DRY:    state_next = ST_BLEND;
      ST_BLEND:  state_next = ST_FBOP;
      ST_FBOP:   state_next = ST_WETOP;
      ST_WETOP:  state_next = ST_LLPF;
      ST_LLPF:   state_next = ST_MIX;
      ST_MIX:    state_next = ST_SAT;
      ST_SAT:    state_next = ST_SATW;
      ST_SATW:   state_next = ST_CMP;
      ST_CMP:    state_next = ST_CMPW;
      ST_CMPW:   state_next = ST_LOOP;
      ST_LOOP:   state_next = ST_LOOPW;
      ST_LOOPW:  state_next = ST_FBWAIT;
      ST_FBWAIT: state_next = ST_WRITE;
      ST_WRITE:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and memory port.
  always_comb begin
    in_ready    = 1'b0;
    mem_wr_en   = 1'b0;
    mem_rd_addr = pos1[POS_W-1:8];
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_DLY2:  mem_rd_addr = pos1[POS_W-1:8];
      ST_RD1B:  mem_rd_addr = pos1[POS_W-1:8] + 1'b1;
      ST_LPF:   mem_rd_addr = pos2[POS_W-1:8];
      ST_TAP1A: mem_rd_addr = pos2[POS_W-1:8] + 1'b1;
      ST_WRITE: mem_wr_en = out_free;
      default:  mem_rd_addr = pos1[POS_W-1:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= RST_PHASE_STEP;
      depth_samples    <= RST_DEPTH;
      base_delay       <= RST_BASE_DELAY;
      feedback_gain    <= RST_FEEDBACK;
      wet_mix          <= RST_WET_MIX;
      tap_phase_offset <= RST_TAP_OFFSET;
      comp_threshold   <= RST_COMP_THRESH;
      comp_ratio       <= RST_COMP_RATIO;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PHASE_STEP:  phase_step       <= cfg_data[18:0];
        REG_DEPTH:       depth_samples    <= cfg_data[16:0];
        REG_BASE_DELAY:  base_delay       <= cfg_data[16:0];
        REG_FEEDBACK:    feedback_gain    <= cfg_data[15:0];
        REG_WET_MIX:     wet_mix          <= cfg_data[16:0];
        REG_TAP_OFFSET:  tap_phase_offset <= cfg_data[15:0];
        REG_COMP_THRESH: comp_threshold   <= cfg_data[14:0];
        REG_COMP_RATIO:  comp_ratio       <= cfg_data[16:0];
        default:         phase_step       <= phase_step;
      endcase
    end
  end

  // Filter state, LFO phase and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase  <= '0;
      hp_track   <= '0;
      lp_track   <= '0;
      loop_track <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A finished sample refills the output register in the cycle that
      // frees it, so the result is never dropped.
      if ((state == ST_WRITE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE:  if (accept) lfo_phase <= lfo_phase + {13'd0, phase_step};
        ST_HPF:   hp_track <= hp_track + prod_sh16[23:0];
        ST_LPF:   lp_track <= lp_track + prod_sh16[23:0];
        ST_MIX:   loop_track <= loop_track + prod_sh16[23:0];
        default:  lfo_phase <= lfo_phase;
      endcase
    end
  end

  // Datapath: operands load into opa and opb; each product is used from the product register.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          x_r <= in_sample;
          opa <= {{2{in_sample[15]}}, in_sample, 8'h00} - {{2{hp_track[23]}}, hp_track};
          opb <= {2'b00, ALPHA_HP};
        end
      end
      ST_MOD1: begin
        opa <= {9'd0, depth_samples};
        opb <= {{2{sine1[15]}}, sine1};
      end
      ST_HPF: begin
        opa <= {9'd0, depth_samples};
        opb <= {{2{sine2[15]}}, sine2};
      end
      ST_DLY1: begin
        d1   <= d_clamped;
        hp_r <= hp_sat;
      end
      ST_DLY2: begin
        d2  <= d_clamped;
        opa <= {hp_r[24], hp_r} - {{2{lp_track[23]}}, lp_track};
        opb <= {2'b00, ALPHA_LP};
      end
      ST_RD1B: begin
        opa <= {{10{mem_rd_data[15]}}, mem_rd_data};
        opb <= {9'd0, inv1};
      end
      ST_LPF: begin
        opa <= {{10{mem_rd_data[15]}}, mem_rd_data};
        opb <= {9'd0, frac1};
      end
      ST_TAP1A: begin
        acc <= prod;
        opa <= {{10{mem_rd_data[15]}}, mem_rd_data};
        opb <= {9'd0, inv2};
      end
      ST_TAP1B: begin
        t1  <= sum_acc[23:8];
        opa <= {{10{mem_rd_data[15]}}, mem_rd_data};
        opb <= {9'd0, frac2};
      end
      ST_TAP2A: begin
        acc <= prod;
        opa <= {{10{t1[15]}}, t1};
        opb <= 18'(BLEND_A);
      end
      ST_TAP2B: begin
        t2  <= sum_acc[23:8];
        opa <= {{10{x_r[15]}}, x_r};
        opb <= {1'b0, mix_inv};
      end
      ST_DRY: begin
        acc <= prod;
        opa <= {{10{t2[15]}}, t2};
        opb <= 18'(BLEND_B);
      end
      ST_BLEND: acc_dry <= prod;
      ST_FBOP:  dec <= sum_acc[31:16];
      ST_WETOP: begin
        opa <= {{2{dec[15]}}, dec, 8'h00} - {{2{loop_track[23]}}, loop_track};
        opb <= {2'b00, ALPHA_FB};
      end
      ST_LLPF: begin
        opa <= {{10{dec[15]}}, dec};
        opb <= {1'b0, mix};
      end
      ST_SAT: begin
        y_r    <= y_sat;
        lp_r   <= loop_track[23:8];
        lp_neg <= loop_track[23];
      end
      ST_SATW: begin
        tb_r <= tanh_lo;
        opa  <= {10'd0, tanh_hi - tanh_lo};
        opb  <= {2'b00, sat_frac};
      end
      ST_CMPW: begin
        t_r <= t_new;
        opa <= {{8{t_over[17]}}, t_over};
        opb <= {1'b0, comp_ratio};
      end
      ST_LOOPW: begin
        opa <= {{9{loop_val[16]}}, loop_val};
        opb <= {2'b00, feedback_gain};
      end
      ST_WRITE: begin
        if (out_free) begin
          out_sample <= y_r;
        end
      end
      default: x_r <= x_r;
    endcase
  end

  // The product for the mix step arrives during ST_SAT; y_sat uses it there.
  // The loop operands are loaded at ST_LOOPW from the compressor result that
  // used the product of ST_CMPW's operands; their product is ready in
  // ST_WRITE after the ST_FBWAIT step and stays there while the step stalls.

endmodule

@@ rtl/flg_checker.sv @@
// ----------------------------------------------------------------------------
// flg_checker
// Port-level checks of the flanger's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_sample
);

  // A waiting result is neither dropped nor altered.
  `FLG_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_sample))

  // One sample at a time: a transaction closes the input side at once.
  `FLG_ASSERT(a_one_in_flight, clk, rst, in_valid && in_ready |=> !in_ready)

  // A new result appears only as the sequencer returns to idle.
  `FLG_ASSERT(a_result_then_idle, clk, rst, $rose(out_valid) |-> in_ready)

  // Reset leaves no result pending and the input side open.
  `FLG_ASSERT_NR(a_reset_clean, clk, rst |=> !out_valid && in_ready)

endmodule

bind flanger_effect_top flg_checker u_flg_checker (.*);
